// File: hw/rtl/modular_arithmetic_unit_core_assert.svh
// Assertion macros for the modular arithmetic unit.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef MODULAR_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define MAU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define MAU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mau_pkg.sv
// Package for the modular arithmetic unit: command codes, sequencer states,
// and the control/status structs of the shared modular step unit. No dependencies.
`timescale 1ns / 1ps

package mau_pkg;

    localparam int RESULT_WIDTH = 32;
    localparam int CMD_WIDTH    = 3;

    // Modulus after reset (1e9 + 7)
    localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_POW = 3'd3,
        CMD_INV = 3'd4,
        CMD_DIV = 3'd5
    } cmd_t;

    typedef enum logic {
        MODE_REDUCE,
        MODE_MULMOD
    } unit_mode_t;

    typedef struct packed {
        logic       start;
        unit_mode_t mode;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_A,
        ST_WAIT_A,
        ST_RED_B,
        ST_WAIT_B,
        ST_DISPATCH,
        ST_POW_STEP,
        ST_WAIT_ACC,
        ST_POW_SQ,
        ST_WAIT_SQ,
        ST_POW_END,
        ST_MUL_AB,
        ST_WAIT_AB,
        ST_NORM,
        ST_DONE
    } state_t;

endpackage

// File: hw/rtl/mau_modstep.sv
// Shared modular step unit: r = (2r + addend) mod m, one bit per cycle.
// Reduces a wide magnitude or forms an interleaved modular product. Uses mau_pkg.
`timescale 1ns / 1ps

module mau_modstep #(
    parameter int MOD_WIDTH     = 31,
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mau_pkg::unit_ctl_t       ctl,
    input  logic [OPERAND_WIDTH-1:0] load_word,
    input  logic [MOD_WIDTH-1:0]     addend,
    input  logic [MOD_WIDTH-1:0]     modulus,
    output logic [MOD_WIDTH-1:0]     rem,
    output mau_pkg::unit_sts_t       sts
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);
    localparam int T_W   = MOD_WIDTH + 3;
    localparam int ALIGN = OPERAND_WIDTH - MOD_WIDTH;

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [OPERAND_WIDTH-1:0] sh_reg, sh_next;
    logic [MOD_WIDTH-1:0]     x_reg, x_next;
    logic [MOD_WIDTH-1:0]     r_reg, r_next;
    mau_pkg::unit_mode_t      mode_reg, mode_next;

    logic                     step_bit;
    logic [T_W-1:0]           add_val;
    logic [T_W-1:0]           t0, t1, t2, m_ext;
    logic [MOD_WIDTH-1:0]     r_step;

    // One step: double, add, then take off m once or twice
    always_comb begin
        step_bit = sh_reg[OPERAND_WIDTH-1];
        if (mode_reg == mau_pkg::MODE_REDUCE) begin
            add_val = T_W'(step_bit);
        end else begin
            add_val = step_bit ? T_W'(x_reg) : '0;
        end
        m_ext = T_W'(modulus);
        t0    = {2'b00, r_reg, 1'b0} + add_val;
        t1    = t0 - m_ext;
        t2    = t0 - {m_ext[T_W-2:0], 1'b0};
        if (!t2[T_W-1]) begin
            r_step = t2[MOD_WIDTH-1:0];
        end else if (!t1[T_W-1]) begin
            r_step = t1[MOD_WIDTH-1:0];
        end else begin
            r_step = t0[MOD_WIDTH-1:0];
        end
    end

    // Load on start, advance while busy, pulse done after the last step
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        mode_next = mode_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            r_next    = '0;
            x_next    = addend;
            mode_next = ctl.mode;
            if (ctl.mode == mau_pkg::MODE_REDUCE) begin
                sh_next  = load_word;
                cnt_next = CNT_W'(OPERAND_WIDTH);
            end else begin
                sh_next  = load_word << ALIGN;
                cnt_next = CNT_W'(MOD_WIDTH);
            end
        end else if (busy_reg) begin
            r_next   = r_step;
            sh_next  = {sh_reg[OPERAND_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        sh_reg   <= sh_next;
        x_reg    <= x_next;
        r_reg    <= r_next;
        mode_reg <= mode_next;
    end

    assign rem      = r_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

// File: hw/rtl/modular_arithmetic_unit_core.sv
// Modular arithmetic unit: add, subtract, multiply, power, Fermat inverse and
// divide of two signed operands modulo a programmable modulus. All arithmetic runs
// through one bit-serial modular step unit (mau_modstep) under a sequencer, so one
// transfer is in flight at a time and s_tready stays low until its result is in the
// output register. Each operand is first reduced by the step unit; power forms up to
// two modular products for each of up to OPERAND_WIDTH - 1 exponent bits, and inverse
// and divide raise to the exponent m - 2. The output register lets the next command be
// taken while the previous result still waits on m_tready. Power and inverse give a
// signed result, negative for a negative base with an odd exponent; the other commands
// return 0 to m - 1.
// Depends on mau_pkg, mau_modstep and modular_arithmetic_unit_core_assert.svh.
`timescale 1ns / 1ps

module modular_arithmetic_unit_core #(
    parameter int MOD_WIDTH     = 31,
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Modulus register write
    input  logic                                   cfg_wr_en,
    input  logic [MOD_WIDTH-1:0]                   cfg_wr_data,
    // Command stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata from bit 0: operand_a, operand_b, zero padding
    input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
    // tuser: cmd
    input  logic [mau_pkg::CMD_WIDTH-1:0]          s_tuser,
    // Result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata from bit 0: result
    output logic [mau_pkg::RESULT_WIDTH-1:0]       m_tdata
);

    localparam int OW    = OPERAND_WIDTH;
    localparam int MW    = MOD_WIDTH;
    localparam int SUM_W = MOD_WIDTH + 2;
    localparam int RW    = mau_pkg::RESULT_WIDTH;
    localparam logic [MW-1:0] MOD_RESET = MW'(mau_pkg::MODULUS_RESET);

    mau_pkg::state_t    state_reg, state_next;
    logic [MW-1:0]      modulus_reg, modulus_next;
    logic               out_valid_reg, out_valid_next;
    logic [RW-1:0]      out_data_reg, out_data_next;

    mau_pkg::cmd_t      cmd_reg, cmd_next;
    logic [OW-1:0]      opa_reg, opa_next;
    logic [OW-1:0]      opb_reg, opb_next;
    logic               a_neg_reg, a_neg_next;
    logic [MW-1:0]      a_mag_reg, a_mag_next;
    logic               b_neg_reg, b_neg_next;
    logic [MW-1:0]      b_mag_reg, b_mag_next;
    logic               acc_neg_reg, acc_neg_next;
    logic [MW-1:0]      acc_mag_reg, acc_mag_next;
    logic               base_neg_reg, base_neg_next;
    logic [MW-1:0]      base_mag_reg, base_mag_next;
    logic [OW-1:0]      exp_reg, exp_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [RW-1:0]    res_reg, res_next;

    mau_pkg::unit_ctl_t unit_ctl;
    mau_pkg::unit_sts_t unit_sts;
    logic [OW-1:0]      unit_word;
    logic [MW-1:0]      unit_addend;
    logic [MW-1:0]      unit_rem;

    logic               in_xfer;
    logic               cmd_ok;
    logic               out_free;
    logic [OW-1:0]      a_abs, b_abs;
    logic               exp_pos;
    logic               mod_gt2;
    logic [OW-1:0]      inv_exp;
    logic signed [SUM_W-1:0] a_sval, b_sval, mod_s, rem_s;
    logic signed [RW-1:0]    acc_sres;

    // Shared modular step unit
    mau_modstep #(
        .MOD_WIDTH    (MOD_WIDTH),
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (unit_ctl),
        .load_word(unit_word),
        .addend   (unit_addend),
        .modulus  (modulus_reg),
        .rem      (unit_rem),
        .sts      (unit_sts)
    );

    // Helpers derived from the held operands
    always_comb begin
        in_xfer  = s_tvalid && s_tready;
        cmd_ok   = (s_tuser <= mau_pkg::CMD_DIV);
        out_free = !out_valid_reg || m_tready;
        a_abs    = opa_reg[OW-1] ? (~opa_reg + OW'(1)) : opa_reg;
        b_abs    = opb_reg[OW-1] ? (~opb_reg + OW'(1)) : opb_reg;
        exp_pos  = (opb_reg != '0) && !opb_reg[OW-1];
        mod_gt2  = (modulus_reg > MW'(2));
        inv_exp  = OW'(modulus_reg) - OW'(2);
        mod_s    = SUM_W'(modulus_reg);
        rem_s    = SUM_W'(unit_rem);
        a_sval   = a_neg_reg ? (SUM_W'(0) - SUM_W'(a_mag_reg)) : SUM_W'(a_mag_reg);
        b_sval   = b_neg_reg ? (SUM_W'(0) - SUM_W'(b_mag_reg)) : SUM_W'(b_mag_reg);
        acc_sres = acc_neg_reg ? (RW'(0) - RW'(acc_mag_reg)) : RW'(acc_mag_reg);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mau_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if ((modulus_reg == '0) || !cmd_ok) begin
                        state_next = mau_pkg::ST_DONE;
                    end else begin
                        state_next = mau_pkg::ST_RED_A;
                    end
                end
            end
            mau_pkg::ST_RED_A: state_next = mau_pkg::ST_WAIT_A;
            mau_pkg::ST_WAIT_A: begin
                if (unit_sts.done) state_next = mau_pkg::ST_RED_B;
            end
            mau_pkg::ST_RED_B: state_next = mau_pkg::ST_WAIT_B;
            mau_pkg::ST_WAIT_B: begin
                if (unit_sts.done) state_next = mau_pkg::ST_DISPATCH;
            end
            mau_pkg::ST_DISPATCH: begin
                case (cmd_reg) inside
                    mau_pkg::CMD_ADD, mau_pkg::CMD_SUB: state_next = mau_pkg::ST_NORM;
                    mau_pkg::CMD_MUL: state_next = mau_pkg::ST_MUL_AB;
                    mau_pkg::CMD_POW: begin
                        if ((a_mag_reg == '0) || !exp_pos) state_next = mau_pkg::ST_DONE;
                        else state_next = mau_pkg::ST_POW_STEP;
                    end
                    mau_pkg::CMD_INV: begin
                        if ((a_mag_reg == '0) || !mod_gt2) state_next = mau_pkg::ST_DONE;
                        else state_next = mau_pkg::ST_POW_STEP;
                    end
                    mau_pkg::CMD_DIV: begin
                        if (b_mag_reg == '0) state_next = mau_pkg::ST_DONE;
                        else if (!mod_gt2) state_next = mau_pkg::ST_MUL_AB;
                        else state_next = mau_pkg::ST_POW_STEP;
                    end
                    default: state_next = mau_pkg::ST_DONE;
                endcase
            end
            mau_pkg::ST_POW_STEP: begin
                if (exp_reg == '0) state_next = mau_pkg::ST_POW_END;
                else if (exp_reg[0]) state_next = mau_pkg::ST_WAIT_ACC;
                else state_next = mau_pkg::ST_POW_SQ;
            end
            mau_pkg::ST_WAIT_ACC: begin
                if (unit_sts.done) state_next = mau_pkg::ST_POW_SQ;
            end
            mau_pkg::ST_POW_SQ: begin
                if (exp_reg[OW-1:1] != '0) state_next = mau_pkg::ST_WAIT_SQ;
                else state_next = mau_pkg::ST_POW_STEP;
            end
            mau_pkg::ST_WAIT_SQ: begin
                if (unit_sts.done) state_next = mau_pkg::ST_POW_STEP;
            end
            mau_pkg::ST_POW_END: begin
                if (cmd_reg == mau_pkg::CMD_DIV) state_next = mau_pkg::ST_MUL_AB;
                else state_next = mau_pkg::ST_DONE;
            end
            mau_pkg::ST_MUL_AB: state_next = mau_pkg::ST_WAIT_AB;
            mau_pkg::ST_WAIT_AB: begin
                if (unit_sts.done) state_next = mau_pkg::ST_NORM;
            end
            mau_pkg::ST_NORM: begin
                if (!sum_reg[SUM_W-1] && (sum_reg < mod_s)) state_next = mau_pkg::ST_DONE;
            end
            mau_pkg::ST_DONE: begin
                if (out_free) state_next = mau_pkg::ST_IDLE;
            end
            default: state_next = mau_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and step unit commands
    always_comb begin
        s_tready       = 1'b0;
        unit_ctl.start = 1'b0;
        unit_ctl.mode  = mau_pkg::MODE_MULMOD;
        unit_word      = OW'(base_mag_reg);
        unit_addend    = base_mag_reg;
        unique case (state_reg)
            mau_pkg::ST_IDLE: s_tready = 1'b1;
            mau_pkg::ST_RED_A: begin
                unit_ctl.start = 1'b1;
                unit_ctl.mode  = mau_pkg::MODE_REDUCE;
                unit_word      = a_abs;
            end
            mau_pkg::ST_RED_B: begin
                unit_ctl.start = 1'b1;
                unit_ctl.mode  = mau_pkg::MODE_REDUCE;
                unit_word      = b_abs;
            end
            mau_pkg::ST_POW_STEP: begin
                unit_ctl.start = (exp_reg != '0) && exp_reg[0];
                unit_addend    = acc_mag_reg;
            end
            mau_pkg::ST_POW_SQ: begin
                unit_ctl.start = (exp_reg[OW-1:1] != '0);
            end
            mau_pkg::ST_MUL_AB: begin
                unit_ctl.start = 1'b1;
                unit_word      = OW'(b_mag_reg);
                unit_addend    = a_mag_reg;
            end
            default: begin
                unit_ctl.start = 1'b0;
            end
        endcase
    end

    // Datapath registers
    always_comb begin
        modulus_next   = cfg_wr_en ? cfg_wr_data : modulus_reg;
        cmd_next       = cmd_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        a_neg_next     = a_neg_reg;
        a_mag_next     = a_mag_reg;
        b_neg_next     = b_neg_reg;
        b_mag_next     = b_mag_reg;
        acc_neg_next   = acc_neg_reg;
        acc_mag_next   = acc_mag_reg;
        base_neg_next  = base_neg_reg;
        base_mag_next  = base_mag_reg;
        exp_next       = exp_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            mau_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    cmd_next = mau_pkg::cmd_t'(s_tuser);
                    opa_next = s_tdata[OW-1:0];
                    opb_next = s_tdata[2*OW-1:OW];
                    res_next = '0;
                end
            end
            mau_pkg::ST_WAIT_A: begin
                a_neg_next = opa_reg[OW-1];
                a_mag_next = unit_rem;
            end
            mau_pkg::ST_WAIT_B: begin
                b_neg_next = opb_reg[OW-1];
                b_mag_next = unit_rem;
            end
            mau_pkg::ST_DISPATCH: begin
                acc_neg_next = 1'b0;
                acc_mag_next = MW'(1);
                case (cmd_reg)
                    mau_pkg::CMD_ADD: sum_next = a_sval + b_sval;
                    mau_pkg::CMD_SUB: sum_next = a_sval - b_sval;
                    mau_pkg::CMD_POW: begin
                        base_neg_next = a_neg_reg;
                        base_mag_next = a_mag_reg;
                        exp_next      = opb_reg;
                        res_next      = (a_mag_reg == '0) ? RW'(0) : RW'(1);
                    end
                    mau_pkg::CMD_INV: begin
                        base_neg_next = a_neg_reg;
                        base_mag_next = a_mag_reg;
                        exp_next      = inv_exp;
                        res_next      = (a_mag_reg == '0) ? RW'(0) : RW'(1);
                    end
                    mau_pkg::CMD_DIV: begin
                        base_neg_next = b_neg_reg;
                        base_mag_next = b_mag_reg;
                        exp_next      = inv_exp;
                        res_next      = '0;
                        // Exponent m - 2 not positive: inverse of a non-zero value is 1
                        if (!mod_gt2) begin
                            b_neg_next = 1'b0;
                            b_mag_next = MW'(1);
                        end
                    end
                    default: res_next = '0;
                endcase
            end
            mau_pkg::ST_WAIT_ACC: begin
                if (unit_sts.done) begin
                    acc_mag_next = unit_rem;
                    acc_neg_next = acc_neg_reg ^ base_neg_reg;
                end
            end
            mau_pkg::ST_POW_SQ: begin
                exp_next = exp_reg >> 1;
            end
            mau_pkg::ST_WAIT_SQ: begin
                if (unit_sts.done) begin
                    base_mag_next = unit_rem;
                    base_neg_next = 1'b0;
                end
            end
            mau_pkg::ST_POW_END: begin
                // Divide carries the inverse on as the multiplier
                if (cmd_reg == mau_pkg::CMD_DIV) begin
                    b_neg_next = acc_neg_reg;
                    b_mag_next = acc_mag_reg;
                end else begin
                    res_next = acc_sres;
                end
            end
            mau_pkg::ST_WAIT_AB: begin
                if (unit_sts.done) begin
                    sum_next = (a_neg_reg ^ b_neg_reg) ? (SUM_W'(0) - rem_s) : rem_s;
                end
            end
            mau_pkg::ST_NORM: begin
                // Step into 0 .. m-1, one add or subtract per cycle
                if (sum_reg[SUM_W-1]) begin
                    sum_next = sum_reg + mod_s;
                end else if (sum_reg >= mod_s) begin
                    sum_next = sum_reg - mod_s;
                end else begin
                    res_next = RW'(sum_reg);
                end
            end
            mau_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default: begin
                sum_next = sum_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mau_pkg::ST_IDLE;
            modulus_reg   <= MOD_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            modulus_reg   <= modulus_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        cmd_reg      <= cmd_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        a_neg_reg    <= a_neg_next;
        a_mag_reg    <= a_mag_next;
        b_neg_reg    <= b_neg_next;
        b_mag_reg    <= b_mag_next;
        acc_neg_reg  <= acc_neg_next;
        acc_mag_reg  <= acc_mag_next;
        base_neg_reg <= base_neg_next;
        base_mag_reg <= base_mag_next;
        exp_reg      <= exp_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks on the sequencer and the shared unit
`include "modular_arithmetic_unit_core_assert.svh"

    `MAU_ASSERT_IMP(a_ready_unit_idle, s_tready, !unit_sts.busy, "input ready while step unit busy")
    `MAU_ASSERT_IMP(a_start_unit_free, unit_ctl.start, !unit_sts.busy && !unit_sts.done, "step unit restarted while in use")
    `MAU_ASSERT_IMP(a_done_in_wait, unit_sts.done, (state_reg == mau_pkg::ST_WAIT_A) || (state_reg == mau_pkg::ST_WAIT_B) || (state_reg == mau_pkg::ST_WAIT_ACC) || (state_reg == mau_pkg::ST_WAIT_SQ) || (state_reg == mau_pkg::ST_WAIT_AB), "step unit finished outside a wait state")
    `MAU_ASSERT_NXT(a_busy_after_xfer, in_xfer, !s_tready, "second transfer taken while a command is in flight")

endmodule
